>>> sv/b64e_pkg.sv
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
package b64e_pkg;

  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned GroupWidth   = 24;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0] PadChar = 8'h3D;

  // One encoded group handed from front to back.
  typedef struct packed {
    logic [GroupWidth-1:0] bits;   // b0 in [23:16], b1 in [15:8], b2 in [7:0]
    logic [2:0]            nchars; // alphabet characters before padding, 2..4
    logic                  fin;    // group closes the message
  } group_t;

  // Standard base64 alphabet.
  function automatic logic [7:0] alphabet(input logic [5:0] idx);
    logic [7:0] ch;
    if (idx < 6'd26) begin
      ch = 8'h41 + {2'b00, idx};
    end else if (idx < 6'd52) begin
      ch = 8'h61 + {2'b00, idx - 6'd26};
    end else if (idx < 6'd62) begin
      ch = 8'h30 + {2'b00, idx - 6'd52};
    end else if (idx == 6'd62) begin
      ch = 8'h2B;
    end else begin
      ch = 8'h2F;
    end
    return ch;
  endfunction

endpackage

>>> sv/base64_stream_encoder_top.sv
// Top level of the base64 stream encoder: front, group queue and character back end.
//
//  channel | dir | tdata (low bit up)  | tlast              | tuser
//  s_axis  | in  | data_byte[7:0]      | final_byte         | -
//  m_axis  | out | out_char[7:0]       | message_end        | -
//
// Cycles: the front takes one byte per cycle while the group queue has room;
// the back emits one character per cycle, four per group, while a group is
// queued and m_axis does not stall. The byte closing a group goes first into
// the queue, then its first character into the back's output register.
// Reset (rst, synchronous) drops pending bytes and empties the queue.
// A stall on m_axis holds the back; the front keeps taking bytes until the queue fills.
module base64_stream_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = b64e_pkg::QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // final_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast    // message_end
);

  logic             q_full;
  logic             q_push;
  b64e_pkg::group_t q_in;
  logic             q_pop;
  logic             q_head_valid;
  b64e_pkg::group_t q_head;

  // front: gathers bytes, closes a group on the third byte or the final one
  b64e_front u_front (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  // decouples byte intake from character output
  b64e_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_data (q_head)
  );

  // back: alphabet lookup, '=' padding, message_end on the fourth char of the last group
  b64e_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_head_valid),
    .head_data    (q_head),
    .pop          (q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

>>> sv/b64e_front.sv
// Input side: collects bytes into 24-bit groups and pushes closed groups to the queue.
module b64e_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [b64e_pkg::ByteWidth-1:0] s_axis_tdata,
  input  logic                          s_axis_tlast,
  input  logic                          q_full,
  output logic                          q_push,
  output b64e_pkg::group_t              q_data
);

  logic [15:0] pending;
  logic [1:0]  count;
  logic        accept;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign q_push        = accept && (count == 2'd2 || s_axis_tlast);

  always_comb begin
    q_data.fin = s_axis_tlast;
    case (count)
      2'd0: begin
        q_data.bits   = {s_axis_tdata, 16'h0000};
        q_data.nchars = 3'd2;
      end
      2'd1: begin
        q_data.bits   = {pending[15:8], s_axis_tdata, 8'h00};
        q_data.nchars = 3'd3;
      end
      default: begin
        q_data.bits   = {pending, s_axis_tdata};
        q_data.nchars = 3'd4;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (accept) begin
      if (q_push) begin
        count <= 2'd0;
      end else begin
        count <= count + 2'd1;
      end
    end
  end

  // pending bytes: first in [15:8], second in [7:0]
  always_ff @(posedge clk) begin
    if (accept && !q_push) begin
      if (count == 2'd0) begin
        pending <= {s_axis_tdata, 8'h00};
      end else begin
        pending[7:0] <= s_axis_tdata;
      end
    end
  end

endmodule

>>> sv/b64e_queue.sv
// Small register FIFO of groups between the front and back.
module b64e_queue #(
  parameter int unsigned DEPTH = b64e_pkg::QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64e_pkg::group_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output b64e_pkg::group_t head_data
);

  localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntWidth = $clog2(DEPTH + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

  b64e_pkg::group_t entries [DEPTH];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] used;
  logic                do_push;
  logic                do_pop;

  assign full       = (used == FullCnt);
  assign head_valid = (used != '0);
  assign head_data  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        used <= used + 1'b1;
      end else if (do_pop && !do_push) begin
        used <= used - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

>>> sv/b64e_back.sv
// Output side: turns the queue head into four characters, one per cycle while m_axis does not stall.
module b64e_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  b64e_pkg::group_t              head_data,
  output logic                          pop,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [b64e_pkg::ByteWidth-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);

  logic [1:0] slot;
  logic       load;
  logic [5:0] idx;
  logic [7:0] ch;

  assign load = head_valid && (!m_axis_tvalid || m_axis_tready);
  assign pop  = load && (slot == 2'd3);

  always_comb begin
    case (slot)
      2'd0:    idx = head_data.bits[23:18];
      2'd1:    idx = head_data.bits[17:12];
      2'd2:    idx = head_data.bits[11:6];
      default: idx = head_data.bits[5:0];
    endcase
    if ({1'b0, slot} < head_data.nchars) begin
      ch = b64e_pkg::alphabet(idx);
    end else begin
      ch = b64e_pkg::PadChar;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot          <= 2'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load) begin
        slot          <= slot + 2'd1;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= ch;
      m_axis_tlast <= head_data.fin && (slot == 2'd3);
    end
  end

endmodule
